[rtl/core/blal_pkg.sv]
// ----------------------------------------------------------------------------
// blal_pkg
// Shared constants, codes and types for the bounded array list core.
// ----------------------------------------------------------------------------
package blal_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int VALUE_W     = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int FUNC_W      = 3;
	localparam int POS_W       = 7;
	localparam int CAP_W       = 7;
	localparam int STATUS_W    = 2;

	localparam int GROUP_SIZE  = 8;
	localparam int GRP_W       = $clog2(GROUP_SIZE);
	localparam int NUM_GROUPS  = MAX_ENTRIES / GROUP_SIZE;
	localparam int GSEL_W      = $clog2(NUM_GROUPS);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_EVAL,
		PH_GRP,
		PH_FIN
	} phase_t;

	typedef struct packed {
		logic                ins_en;
		logic                rem_en;
		logic                eval_en;
		logic [POS_W-1:0]    pos;
		logic [COUNT_W-1:0]  count;
		logic [VALUE_W-1:0]  value;
	} cell_ctl_t;

endpackage

[rtl/core/blal_cell.sv]
// ----------------------------------------------------------------------------
// blal_cell
// One list entry: shifts with its neighbors, compares and offers its value.
// ----------------------------------------------------------------------------
module blal_cell (
	input  logic                              clk,
	input  logic [blal_pkg::IDX_W-1:0]        idx,
	input  blal_pkg::cell_ctl_t               ctl,
	input  logic [blal_pkg::VALUE_W-1:0]      prev_value,
	input  logic [blal_pkg::VALUE_W-1:0]      next_value,
	output logic [blal_pkg::VALUE_W-1:0]      value,
	output logic                              match,
	output logic [blal_pkg::VALUE_W-1:0]      rd_value
);

	logic [blal_pkg::VALUE_W-1:0] value_q;
	logic                         match_q;
	logic [blal_pkg::VALUE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (idx > ctl.pos) begin
				value_q <= prev_value;
			end else if (idx == ctl.pos) begin
				value_q <= ctl.value;
			end
		end else if (ctl.rem_en) begin
			if (idx >= ctl.pos) begin
				value_q <= next_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval_en) begin
			match_q <= (value_q == ctl.value) && (idx < ctl.count);
			rd_q    <= (idx == ctl.pos) ? value_q : '0;
		end
	end

	assign value    = value_q;
	assign match    = match_q;
	assign rd_value = rd_q;

endmodule

[rtl/core/blal_prio.sv]
// ----------------------------------------------------------------------------
// blal_prio
// Two-level priority encoder: registered group stage, then group select.
// ----------------------------------------------------------------------------
module blal_prio (
	input  logic                              clk,
	input  logic [blal_pkg::MAX_ENTRIES-1:0]  match,
	output logic                              found,
	output logic [blal_pkg::IDX_W-1:0]        index
);

	logic [blal_pkg::NUM_GROUPS-1:0] grp_any_s1;
	logic [blal_pkg::GRP_W-1:0]      grp_idx_s1 [blal_pkg::NUM_GROUPS];
	logic [blal_pkg::GRP_W-1:0]      grp_idx    [blal_pkg::NUM_GROUPS];

	always_comb begin
		for (int g = 0; g < blal_pkg::NUM_GROUPS; g++) begin
			grp_idx[g] = '0;
			for (int j = blal_pkg::GROUP_SIZE - 1; j >= 0; j--) begin
				if (match[g*blal_pkg::GROUP_SIZE + j]) begin
					grp_idx[g] = blal_pkg::GRP_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < blal_pkg::NUM_GROUPS; g++) begin
			grp_any_s1[g] <= |match[g*blal_pkg::GROUP_SIZE +: blal_pkg::GROUP_SIZE];
			grp_idx_s1[g] <= grp_idx[g];
		end
	end

	always_comb begin
		found = 1'b0;
		index = '0;
		for (int g = blal_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				found = 1'b1;
				index = {blal_pkg::GSEL_W'(g), grp_idx_s1[g]};
			end
		end
	end

endmodule

[rtl/core/bounded_array_list_core.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_core
// Ordered list of bounded length held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Sequencing: an accepted transaction passes through the evaluate, group
// encode and finish steps of the sequencer before its result is registered;
// no new transaction is taken until then, and finish waits on a stalled result.
// Reset: entry count cleared, capacity set to 64, entry contents undefined.
// ----------------------------------------------------------------------------
module bounded_array_list_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [blal_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [blal_pkg::FUNC_W-1:0]         func,
	input  logic [blal_pkg::POS_W-1:0]          position,
	input  logic [blal_pkg::VALUE_W-1:0]        value_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [blal_pkg::STATUS_W-1:0]       status,
	output logic [blal_pkg::VALUE_W-1:0]        value_out,
	output logic                                found,
	output logic [blal_pkg::IDX_W-1:0]          found_index,
	output logic [blal_pkg::COUNT_W-1:0]        count,
	output logic                                is_empty,
	output logic                                is_full
);

	blal_pkg::phase_t                  phase_q, phase_d;
	logic [blal_pkg::CAP_W-1:0]        cap_q;
	logic [blal_pkg::COUNT_W-1:0]      count_q;
	logic [blal_pkg::COUNT_W-1:0]      cap_eff;
	logic [blal_pkg::FUNC_W-1:0]       func_q;
	logic [blal_pkg::POS_W-1:0]        pos_q;
	logic [blal_pkg::VALUE_W-1:0]      val_q;
	logic [blal_pkg::STATUS_W-1:0]     stat_q, stat_d;
	logic                              rd_ok_q, rd_ok_d;
	logic                              srch_q;
	logic [blal_pkg::VALUE_W-1:0]      rdata_q, rd_or;
	logic                              ins_ok, rem_ok;
	logic                              out_load;
	blal_pkg::cell_ctl_t               ctl;

	logic [blal_pkg::VALUE_W-1:0]      cell_val [blal_pkg::MAX_ENTRIES];
	logic [blal_pkg::VALUE_W-1:0]      cell_rd  [blal_pkg::MAX_ENTRIES];
	logic [blal_pkg::MAX_ENTRIES-1:0]  cell_match;
	logic                              enc_found;
	logic [blal_pkg::IDX_W-1:0]        enc_index;

	logic                              out_valid_q;
	logic [blal_pkg::STATUS_W-1:0]     status_q;
	logic [blal_pkg::VALUE_W-1:0]      value_out_q;
	logic                              found_q;
	logic [blal_pkg::IDX_W-1:0]        found_index_q;
	logic [blal_pkg::COUNT_W-1:0]      count_out_q;
	logic                              is_empty_q;
	logic                              is_full_q;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = blal_pkg::COUNT_W'(1);
		end else if (int'(cap_q) > blal_pkg::MAX_ENTRIES) begin
			cap_eff = blal_pkg::COUNT_W'(blal_pkg::MAX_ENTRIES);
		end else begin
			cap_eff = blal_pkg::COUNT_W'(cap_q);
		end
	end

	always_comb begin
		ins_ok  = 1'b0;
		rem_ok  = 1'b0;
		rd_ok_d = 1'b0;
		stat_d  = blal_pkg::ST_OK;
		case (func_q)
			blal_pkg::FN_INSERT: begin
				if (pos_q > count_q) begin
					stat_d = blal_pkg::ST_RANGE;
				end else if (count_q >= cap_eff) begin
					stat_d = blal_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			blal_pkg::FN_REMOVE: begin
				if (pos_q >= count_q) begin
					stat_d = blal_pkg::ST_RANGE;
				end else begin
					rem_ok  = 1'b1;
					rd_ok_d = 1'b1;
				end
			end
			blal_pkg::FN_GET: begin
				if (pos_q >= count_q) begin
					stat_d = blal_pkg::ST_RANGE;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_load = (phase_q == blal_pkg::PH_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			blal_pkg::PH_IDLE: begin
				if (in_valid) begin
					phase_d = blal_pkg::PH_EVAL;
				end
			end
			blal_pkg::PH_EVAL: phase_d = blal_pkg::PH_GRP;
			blal_pkg::PH_GRP:  phase_d = blal_pkg::PH_FIN;
			blal_pkg::PH_FIN: begin
				if (out_load) begin
					phase_d = blal_pkg::PH_IDLE;
				end
			end
			default: phase_d = blal_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= blal_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	assign in_stall = (phase_q != blal_pkg::PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= blal_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (phase_q == blal_pkg::PH_EVAL) begin
			if (ins_ok) begin
				count_q <= count_q + 1'b1;
			end else if (rem_ok) begin
				count_q <= count_q - 1'b1;
			end else if (func_q == blal_pkg::FN_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == blal_pkg::PH_IDLE && in_valid) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= value_in;
		end
		if (phase_q == blal_pkg::PH_EVAL) begin
			stat_q  <= stat_d;
			rd_ok_q <= rd_ok_d;
			srch_q  <= (func_q == blal_pkg::FN_SEARCH);
		end
		if (phase_q == blal_pkg::PH_GRP) begin
			rdata_q <= rd_or;
		end
	end

	always_comb begin
		ctl.ins_en  = (phase_q == blal_pkg::PH_EVAL) && ins_ok;
		ctl.rem_en  = (phase_q == blal_pkg::PH_EVAL) && rem_ok;
		ctl.eval_en = (phase_q == blal_pkg::PH_EVAL);
		ctl.pos     = pos_q;
		ctl.count   = count_q;
		ctl.value   = val_q;
	end

	for (genvar i = 0; i < blal_pkg::MAX_ENTRIES; i++) begin : g_cell
		logic [blal_pkg::VALUE_W-1:0] prev_v, next_v;
		if (i == 0) begin : g_first
			assign prev_v = '0;
		end else begin : g_prev
			assign prev_v = cell_val[i-1];
		end
		if (i == blal_pkg::MAX_ENTRIES - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_next
			assign next_v = cell_val[i+1];
		end
		blal_cell u_cell (
			.clk        (clk),
			.idx        (blal_pkg::IDX_W'(i)),
			.ctl        (ctl),
			.prev_value (prev_v),
			.next_value (next_v),
			.value      (cell_val[i]),
			.match      (cell_match[i]),
			.rd_value   (cell_rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < blal_pkg::MAX_ENTRIES; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	blal_prio u_prio (
		.clk   (clk),
		.match (cell_match),
		.found (enc_found),
		.index (enc_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= stat_q;
			value_out_q   <= rd_ok_q ? rdata_q : '0;
			found_q       <= srch_q && enc_found;
			found_index_q <= (srch_q && enc_found) ? enc_index : '0;
			count_out_q   <= count_q;
			is_empty_q    <= (count_q == '0);
			is_full_q     <= (count_q >= cap_eff);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign count       = count_out_q;
	assign is_empty    = is_empty_q;
	assign is_full     = is_full_q;

endmodule

[rtl/core/blal_checker.sv]
// ----------------------------------------------------------------------------
// blal_checker
// Port-level checks for the bounded array list core.
// ----------------------------------------------------------------------------
module blal_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [blal_pkg::STATUS_W-1:0]       status,
	input  logic [blal_pkg::VALUE_W-1:0]        value_out,
	input  logic                                found,
	input  logic [blal_pkg::IDX_W-1:0]          found_index,
	input  logic [blal_pkg::COUNT_W-1:0]        count,
	input  logic                                is_empty
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
			&& $stable(count))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0))
			&& (int'(count) <= blal_pkg::MAX_ENTRIES))
		else $error("occupancy flags inconsistent");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (status == blal_pkg::ST_OK)
			&& ({1'b0, found_index} < count) && (value_out == '0))
		else $error("search hit outside the list");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken back to back");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == blal_pkg::ST_OK) || (status == blal_pkg::ST_RANGE)
			|| (status == blal_pkg::ST_FULL))
		else $error("illegal status code");

endmodule

bind bounded_array_list_core blal_checker u_blal_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.value_out   (value_out),
	.found       (found),
	.found_index (found_index),
	.count       (count),
	.is_empty    (is_empty)
);

[sim/bounded_array_list_core_tb.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_core_tb
// Self-checking testbench for the bounded array list core. A list model in a
// small scoreboard predicts one response per accepted transaction. The
// stimulus is a directed opening, then phases of random list operations
// under several capacity settings, most with random bursts of back-pressure.
// ----------------------------------------------------------------------------
module bounded_array_list_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import blal_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 6;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
		logic                found;
		logic [IDX_W-1:0]    index;
		logic [COUNT_W-1:0]  count;
		logic                empty;
		logic                full;
	} list_resp_t;

	class list_scoreboard;
		logic [VALUE_W-1:0] entries [MAX_ENTRIES];
		int                 entry_count;
		logic [CAP_W-1:0]   capacity_reg;
		list_resp_t         pending_responses [$];
		int                 mismatches;
		int                 responses_seen;
		int                 peak_count;
		int                 status_hits [3];

		function new();
			entry_count    = 0;
			capacity_reg   = CAP_RESET;
			mismatches     = 0;
			responses_seen = 0;
			peak_count     = 0;
			foreach (entries[i]) entries[i] = '0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function int effective_capacity();
			if (capacity_reg == 0)
				return 1;
			if (capacity_reg > MAX_ENTRIES)
				return MAX_ENTRIES;
			return capacity_reg;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			capacity_reg = v;
		endfunction

		function void note_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
				logic [VALUE_W-1:0] v);
			list_resp_t r;
			int cap;
			int i;
			cap = effective_capacity();
			r = '{status: ST_OK, value: '0, found: 1'b0, index: '0, count: '0,
				empty: 1'b0, full: 1'b0};
			case (f)
				FN_INSERT: begin
					if (p > entry_count)
						r.status = ST_RANGE;
					else if (entry_count >= cap)
						r.status = ST_FULL;
					else begin
						for (i = entry_count; i > p; i--)
							entries[i] = entries[i-1];
						entries[p] = v;
						entry_count++;
					end
				end
				FN_REMOVE: begin
					if (p >= entry_count)
						r.status = ST_RANGE;
					else begin
						r.value = entries[p];
						for (i = p; i < entry_count - 1; i++)
							entries[i] = entries[i+1];
						entry_count--;
					end
				end
				FN_GET: begin
					if (p >= entry_count)
						r.status = ST_RANGE;
					else
						r.value = entries[p];
				end
				FN_SEARCH: begin
					for (i = 0; i < entry_count; i++) begin
						if (!r.found && entries[i] == v) begin
							r.found = 1'b1;
							r.index = IDX_W'(i);
						end
					end
				end
				FN_CLEAR: entry_count = 0;
				default: ;
			endcase
			r.count = COUNT_W'(entry_count);
			r.empty = (entry_count == 0);
			r.full  = (entry_count >= cap);
			if (entry_count > peak_count)
				peak_count = entry_count;
			status_hits[r.status]++;
			pending_responses.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp,
					act);
			end
		endfunction

		function void check_response(list_resp_t got);
			list_resp_t exp;
			responses_seen++;
			if (pending_responses.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected response, expected none actual status %0h",
					$time, got.status);
				return;
			end
			exp = pending_responses.pop_front();
			compare_field("status", exp.status, got.status);
			compare_field("value_out", exp.value, got.value);
			compare_field("found", exp.found, got.found);
			compare_field("found_index", exp.index, got.index);
			compare_field("count", exp.count, got.count);
			compare_field("is_empty", exp.empty, got.empty);
			compare_field("is_full", exp.full, got.full);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CAP_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [FUNC_W-1:0]   func;
	logic [POS_W-1:0]    position;
	logic [VALUE_W-1:0]  value_in;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  value_out;
	logic                found;
	logic [IDX_W-1:0]    found_index;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;
	logic                is_full;

	list_scoreboard sb;
	bit             idle_on;
	int             ops_sent;
	int             cfg_writes;

	bounded_array_list_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.value_out   (value_out),
		.found       (found),
		.found_index (found_index),
		.count       (count),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : result_backpressure
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				hold = 0;
				out_stall <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_response('{status, value_out, found, found_index, count, is_empty,
				is_full});
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAIL bounded_array_list_core");
		$finish;
	end

	task automatic send_op(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic [VALUE_W-1:0] v);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= f;
		position <= p;
		value_in <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(f, p, v);
		ops_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
		cfg_writes++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: return VALUE_W'($urandom_range(0, 7));
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
				endcase
			end
		endcase
	endfunction

	task automatic send_random(int ins_w, int rem_w, int clr_w);
		int cnt;
		int r;
		logic [FUNC_W-1:0]  f;
		logic [POS_W-1:0]   p;
		logic [VALUE_W-1:0] v;
		cnt = sb.entry_count;
		v = pick_value();
		r = $urandom_range(0, 99);
		if (r < 2)
			f = FUNC_W'($urandom_range(5, 7));
		else if (r < 2 + clr_w)
			f = FN_CLEAR;
		else begin
			r = $urandom_range(0, 99);
			if (r < ins_w)
				f = FN_INSERT;
			else if (r < ins_w + rem_w)
				f = FN_REMOVE;
			else if (r < ins_w + rem_w + (100 - ins_w - rem_w) / 2)
				f = FN_GET;
			else
				f = FN_SEARCH;
		end
		if ($urandom_range(0, 9) == 0)
			p = POS_W'($urandom_range(0, 127));
		else if (f == FN_INSERT)
			p = POS_W'($urandom_range(0, cnt));
		else
			p = (cnt > 0) ? POS_W'($urandom_range(0, cnt - 1)) : '0;
		if (f == FN_SEARCH && cnt > 0 && $urandom_range(0, 1) == 1)
			v = sb.entries[$urandom_range(0, cnt - 1)];
		send_op(f, p, v);
	endtask

	task automatic run_phase(logic [CAP_W-1:0] cap, int n, int ins_w, int rem_w,
			int clr_w, bit with_idle);
		write_capacity(cap);
		idle_on = with_idle;
		repeat (n) begin
			if ($urandom_range(0, 63) == 0)
				drain_results();
			send_random(ins_w, rem_w, clr_w);
		end
	endtask

	initial begin
		sb         = new();
		idle_on    = 1'b0;
		ops_sent   = 0;
		cfg_writes = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		func       = FN_INSERT;
		position   = '0;
		value_in   = '0;
		out_stall  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		send_op(FN_SEARCH, 7'd0, 32'h0);
		send_op(FN_GET, 7'd0, 32'h0);
		send_op(FN_REMOVE, 7'd0, 32'h0);
		send_op(FN_CLEAR, 7'd0, 32'h0);
		send_op(FN_INSERT, 7'd1, 32'h1);
		send_op(FN_INSERT, 7'd127, 32'h2);
		send_op(3'd5, 7'd0, 32'h0);
		send_op(3'd6, 7'd64, 32'h5555_5555);
		send_op(3'd7, 7'd127, 32'hFFFF_FFFF);
		send_op(FN_INSERT, 7'd0, 32'hFFFF_FFFF);
		send_op(FN_INSERT, 7'd0, 32'h0);
		send_op(FN_INSERT, 7'd2, 32'h8000_0000);
		send_op(FN_INSERT, 7'd1, 32'h1234_5678);
		send_op(FN_GET, 7'd3, 32'h0);
		send_op(FN_GET, 7'd4, 32'h0);
		send_op(FN_SEARCH, 7'd0, 32'hFFFF_FFFF);
		send_op(FN_SEARCH, 7'd0, 32'h5);
		send_op(FN_REMOVE, 7'd1, 32'h0);
		send_op(FN_REMOVE, 7'd3, 32'h0);
		send_op(FN_GET, 7'd64, 32'h0);

		// shrink capacity below the current fill
		write_capacity(7'd2);
		send_op(FN_INSERT, 7'd0, 32'hDEAD_BEEF);
		send_op(FN_INSERT, 7'd5, 32'hDEAD_BEEF);
		send_op(FN_REMOVE, 7'd0, 32'h0);
		send_op(FN_REMOVE, 7'd0, 32'h0);
		send_op(FN_INSERT, 7'd1, 32'hAAAA_5555);
		send_op(FN_CLEAR, 7'd0, 32'h0);

		run_phase(7'd64, 160, 80, 10, 0, 1'b1);
		run_phase(7'd40, 100, 40, 40, 1, 1'b1);
		run_phase(7'd1, 80, 50, 30, 2, 1'b1);
		run_phase(7'd0, 80, 50, 30, 2, 1'b0);
		run_phase(7'd127, 100, 60, 25, 1, 1'b1);
		run_phase(7'd100, 100, 45, 35, 2, 1'b1);
		run_phase(7'd2, 80, 50, 30, 2, 1'b1);
		run_phase(CAP_W'($urandom_range(1, 64)), 100, 50, 30, 2, 1'b1);
		run_phase(7'd64, 100, 20, 60, 2, 1'b1);
		run_phase(7'd64, 150, 50, 30, 1, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d list operations under %0d capacity settings, peak fill %0d.",
			ops_sent, cfg_writes, sb.peak_count);
		$display("Checked %0d responses: %0d ok, %0d bad position, %0d list full; %0d mismatches.",
			sb.responses_seen, sb.status_hits[ST_OK], sb.status_hits[ST_RANGE],
			sb.status_hits[ST_FULL], sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_responses.size() == 0)
			$display("PASS bounded_array_list_core");
		else
			$display("FAIL bounded_array_list_core");
		$finish;
	end

endmodule
